// ===== rtl/mop_pkg.sv =====
// ---------------------------------------------------------------------------
// mop_pkg - shared constants and types for the Mandelbrot orbit period block
// Widths, fixed-point format, register codes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package mop_pkg;

   // Geometry and number format
   localparam int HISTORY_DEPTH  = 20;
   localparam int FRAC_BITS      = 28;
   localparam int INDEX_BITS     = 12;
   localparam int Z_BITS         = 32;
   localparam int PROD_BITS      = 2 * Z_BITS;
   localparam int STEP_BITS      = 28;
   localparam int COUNT_BITS     = 12;
   localparam int TOL_BITS       = 28;
   localparam int ADDR_BITS      = $clog2(HISTORY_DEPTH);
   localparam int FILL_BITS      = $clog2(HISTORY_DEPTH + 1);

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 28;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COORD_STEP  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_ITER    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERIOD_TOL  = 2'd2;

   localparam logic [STEP_BITS-1:0]  STEP_RESET     = 28'd1073742;
   localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = 12'd1500;
   localparam logic [TOL_BITS-1:0]   TOL_RESET      = 28'd1342;

   // Payload types
   typedef logic [INDEX_BITS-1:0]    index_type;
   typedef logic signed [Z_BITS-1:0] orbit_type;

endpackage

`default_nettype wire

// ===== rtl/mop_req_if.sv =====
// ---------------------------------------------------------------------------
// mop_req_if - grid point request channel
// Valid/ready channel carrying one grid point (column, row) per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface mop_req_if;

   logic                 valid;
   logic                 ready;
   mop_pkg::index_type   col_index;
   mop_pkg::index_type   row_index;

   modport source (output valid, output col_index, output row_index, input ready);
   modport sink   (input valid, input col_index, input row_index, output ready);

endinterface

`default_nettype wire

// ===== rtl/mop_rsp_if.sv =====
// ---------------------------------------------------------------------------
// mop_rsp_if - orbit value result channel
// Valid/ready channel carrying one stored orbit value per item.
// ---------------------------------------------------------------------------
`default_nettype none

interface mop_rsp_if;

   logic                 valid;
   logic                 ready;
   mop_pkg::index_type   out_col;
   mop_pkg::index_type   out_row;
   mop_pkg::orbit_type   orbit_real;
   logic                 last_value;

   modport source (output valid, output out_col, output out_row, output orbit_real,
                   output last_value, input ready);
   modport sink   (input valid, input out_col, input out_row, input orbit_real,
                   input last_value, output ready);

endinterface

`default_nettype wire

// ===== rtl/mandelbrot_orbit_period_points.sv =====
// ---------------------------------------------------------------------------
// mandelbrot_orbit_period_points - escape-time iteration with period check
// Iterates z = z*z + c for one grid point, keeps the last real parts of z and,
// for points that never escape, emits the orbit values up to the period found.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   req_if    in    valid / ready    col_index, row_index
//   rsp_if    out   valid / ready    out_col, out_row, orbit_real, last_value
//   csr_*     in    csr_wr_en        csr_index, csr_wr_data (write only)
//
// One point is worked at a time; ready is high only while the sequencer idles.
// Each iteration goes through the shared complex-square multiplier unit, with
// the products registered in ST_MUL and z updated in ST_UPD; the period scan
// is one history read per cycle plus pipeline fill.
// Reset is synchronous and clears control only; a stalled result holds in the
// output register, and the next point is accepted while the final result of
// a point waits.
// ---------------------------------------------------------------------------
`default_nettype none

module mandelbrot_orbit_period_points (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mop_req_if.sink                                  req_if,
   mop_rsp_if.source                                rsp_if,
   input  wire logic                                csr_wr_en,
   input  wire logic [mop_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [mop_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);

   localparam int ZB = mop_pkg::Z_BITS;
   localparam int PB = mop_pkg::PROD_BITS;
   localparam int AB = mop_pkg::ADDR_BITS;
   localparam int FB = mop_pkg::FILL_BITS;
   localparam int CB = mop_pkg::COUNT_BITS;

   localparam logic signed [PB-1:0] TWO_Q    = PB'(2) <<< mop_pkg::FRAC_BITS;
   localparam logic [PB-1:0]        ESC_LIMIT = PB'(4) << (2 * mop_pkg::FRAC_BITS);
   localparam logic signed [PB-1:0] Z_MAX    = (PB'(1) <<< (ZB - 1)) - PB'(1);
   localparam logic signed [PB-1:0] Z_MIN    = -(PB'(1) <<< (ZB - 1));
   localparam logic [AB-1:0]        LAST_SLOT = AB'(mop_pkg::HISTORY_DEPTH - 1);

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_CMUL     = 9'b000000010,
      ST_CSET     = 9'b000000100,
      ST_MUL      = 9'b000001000,
      ST_UPD      = 9'b000010000,
      ST_SCAN     = 9'b000100000,
      ST_SCAN_END = 9'b001000000,
      ST_EMIT_RD  = 9'b010000000,
      ST_EMIT_LD  = 9'b100000000
   } state_type;

   function automatic mop_pkg::orbit_type sat_z(input logic signed [PB-1:0] v);
      mop_pkg::orbit_type r;
      if (v > Z_MAX) begin
         r = ZB'(Z_MAX);
      end else if (v < Z_MIN) begin
         r = ZB'(Z_MIN);
      end else begin
         r = ZB'(v);
      end
      return r;
   endfunction

   // Control registers
   state_type                          state_ff, state_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               chk_ff, chk_in;
   logic [mop_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [CB-1:0]                      max_iter_ff, max_iter_in;
   logic [mop_pkg::TOL_BITS-1:0]       tol_ff, tol_in;

   // Datapath registers
   mop_pkg::index_type                 col_ff, col_in;
   mop_pkg::index_type                 row_ff, row_in;
   mop_pkg::orbit_type                 cr_ff, cr_in;
   mop_pkg::orbit_type                 ci_ff, ci_in;
   mop_pkg::orbit_type                 zr_ff, zr_in;
   mop_pkg::orbit_type                 zi_ff, zi_in;
   logic signed [PB-1:0]               prod0_ff, prod0_in;
   logic signed [PB-1:0]               prod1_ff, prod1_in;
   logic signed [PB-1:0]               prod2_ff, prod2_in;
   logic [CB-1:0]                      count_ff, count_in;
   logic [FB-1:0]                      fill_ff, fill_in;
   logic [AB-1:0]                      scan_addr_ff, scan_addr_in;
   logic [AB-1:0]                      rd_tag_ff, rd_tag_in;
   logic [AB-1:0]                      best_ff, best_in;
   logic [AB-1:0]                      emit_idx_ff, emit_idx_in;
   mop_pkg::orbit_type                 h0_ff, h0_in;
   mop_pkg::index_type                 out_col_ff, out_col_in;
   mop_pkg::index_type                 out_row_ff, out_row_in;
   mop_pkg::orbit_type                 orbit_ff, orbit_in;
   logic                               out_last_ff, out_last_in;

   // History memory
   mop_pkg::orbit_type                 hist_mem [mop_pkg::HISTORY_DEPTH];
   mop_pkg::orbit_type                 rd_data_ff;
   logic                               rd_ok_ff;
   logic                               wr_en;
   logic                               rd_en;
   logic [AB-1:0]                      rd_addr;

   // Shared multiplier operands and iteration arithmetic
   mop_pkg::orbit_type                 mul_a0, mul_b0, mul_a1, mul_b1, mul_a2, mul_b2;
   logic [PB-1:0]                      mag_sq;
   logic                               in_set;
   logic                               counted;
   logic [CB-1:0]                      count_next;
   logic                               store_hit;
   logic signed [PB-1:0]               re_wide;
   logic signed [PB-1:0]               im_wide;
   mop_pkg::orbit_type                 zr_new;
   mop_pkg::orbit_type                 zi_new;

   // Period scan arithmetic
   mop_pkg::orbit_type                 hist_val;
   logic signed [ZB:0]                 diff;
   logic [ZB:0]                        diff_abs;
   logic                               tol_hit;
   logic                               emit_last;
   logic                               out_free;

   assign req_if.ready      = (state_ff == ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_col    = out_col_ff;
   assign rsp_if.out_row    = out_row_ff;
   assign rsp_if.orbit_real = orbit_ff;
   assign rsp_if.last_value = out_last_ff;

   // Multiplier operand select: c products first, then the complex square
   always_comb begin
      mul_a0 = zr_ff;
      mul_b0 = zr_ff;
      mul_a1 = zi_ff;
      mul_b1 = zi_ff;
      mul_a2 = zr_ff;
      mul_b2 = zi_ff;
      if (state_ff == ST_CMUL) begin
         mul_a0 = signed'({{(ZB - mop_pkg::INDEX_BITS){1'b0}}, col_ff});
         mul_b0 = signed'({{(ZB - mop_pkg::STEP_BITS){1'b0}}, step_ff});
         mul_a1 = signed'({{(ZB - mop_pkg::INDEX_BITS){1'b0}}, row_ff});
         mul_b1 = signed'({{(ZB - mop_pkg::STEP_BITS){1'b0}}, step_ff});
      end
      prod0_in = mul_a0 * mul_b0;
      prod1_in = mul_a1 * mul_b1;
      prod2_in = mul_a2 * mul_b2;
   end

   // Escape test and z update from the registered products
   always_comb begin
      mag_sq     = unsigned'(prod0_ff) + unsigned'(prod1_ff);
      in_set     = (mag_sq < ESC_LIMIT);
      counted    = in_set && (count_ff < max_iter_ff);
      count_next = count_ff + CB'(counted);
      store_hit  = ({1'b0, count_next} + (CB + 1)'(mop_pkg::HISTORY_DEPTH - 1))
                   > {1'b0, max_iter_ff};
      re_wide    = ((prod0_ff - prod1_ff) >>> mop_pkg::FRAC_BITS) + PB'(cr_ff);
      im_wide    = (prod2_ff >>> (mop_pkg::FRAC_BITS - 1)) + PB'(ci_ff);
      zr_new     = sat_z(re_wide);
      zi_new     = sat_z(im_wide);
   end

   // Distance of one history value from the first one
   always_comb begin
      hist_val = rd_ok_ff ? rd_data_ff : '0;
      diff     = {hist_val[ZB-1], hist_val} - {h0_ff[ZB-1], h0_ff};
      diff_abs = diff[ZB] ? unsigned'(-diff) : unsigned'(diff);
      tol_hit  = diff_abs < {{(ZB + 1 - mop_pkg::TOL_BITS){1'b0}}, tol_ff};
   end

   // Sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      chk_in       = (state_ff == ST_SCAN);
      step_in      = step_ff;
      max_iter_in  = max_iter_ff;
      tol_in       = tol_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      scan_addr_in = scan_addr_ff;
      rd_tag_in    = scan_addr_ff;
      best_in      = best_ff;
      emit_idx_in  = emit_idx_ff;
      h0_in        = h0_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      orbit_in     = orbit_ff;
      out_last_in  = out_last_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = emit_idx_ff;
      out_free     = !rsp_valid_ff || rsp_if.ready;
      emit_last    = (emit_idx_ff == (best_ff - AB'(1)));

      // configuration writes
      if (csr_wr_en) begin
         unique case (csr_index)
            mop_pkg::CSR_COORD_STEP: step_in     = csr_wr_data[mop_pkg::STEP_BITS-1:0];
            mop_pkg::CSR_MAX_ITER:   max_iter_in = csr_wr_data[CB-1:0];
            mop_pkg::CSR_PERIOD_TOL: tol_in      = csr_wr_data[mop_pkg::TOL_BITS-1:0];
            default: ;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // scan pipeline: first value is the reference, later ones are compared
      if (chk_ff) begin
         if (rd_tag_ff == '0) begin
            h0_in = hist_val;
         end else if (tol_hit) begin
            best_in = rd_tag_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               col_in       = req_if.col_index;
               row_in       = req_if.row_index;
               count_in     = '0;
               fill_in      = '0;
               best_in      = '0;
               scan_addr_in = '0;
               emit_idx_in  = '0;
               state_in     = ST_CMUL;
            end
         end
         ST_CMUL: begin
            state_in = ST_CSET;
         end
         ST_CSET: begin
            cr_in    = sat_z(prod0_ff - TWO_Q);
            ci_in    = sat_z(prod1_ff - TWO_Q);
            zr_in    = sat_z(prod0_ff - TWO_Q);
            zi_in    = sat_z(prod1_ff - TWO_Q);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            zr_in    = zr_new;
            zi_in    = zi_new;
            count_in = count_next;
            if (store_hit && (fill_ff < FB'(mop_pkg::HISTORY_DEPTH))) begin
               wr_en   = 1'b1;
               fill_in = fill_ff + FB'(1);
            end
            if (counted) begin
               state_in = ST_MUL;
            end else if (count_next == max_iter_ff) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            rd_en        = 1'b1;
            rd_addr      = scan_addr_ff;
            scan_addr_in = scan_addr_ff + AB'(1);
            if (scan_addr_ff == LAST_SLOT) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = (best_in == '0) ? ST_IDLE : ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = emit_idx_ff;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               out_col_in   = col_ff;
               out_row_in   = row_ff;
               orbit_in     = hist_val;
               out_last_in  = emit_last;
               rsp_valid_in = 1'b1;
               emit_idx_in  = emit_idx_ff + AB'(1);
               state_in     = emit_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chk_ff       <= 1'b0;
         step_ff      <= mop_pkg::STEP_RESET;
         max_iter_ff  <= mop_pkg::MAX_ITER_RESET;
         tol_ff       <= mop_pkg::TOL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_ff       <= chk_in;
         step_ff      <= step_in;
         max_iter_ff  <= max_iter_in;
         tol_ff       <= tol_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      prod0_ff     <= prod0_in;
      prod1_ff     <= prod1_in;
      prod2_ff     <= prod2_in;
      count_ff     <= count_in;
      fill_ff      <= fill_in;
      scan_addr_ff <= scan_addr_in;
      rd_tag_ff    <= rd_tag_in;
      best_ff      <= best_in;
      emit_idx_ff  <= emit_idx_in;
      h0_ff        <= h0_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      orbit_ff     <= orbit_in;
      out_last_ff  <= out_last_in;
   end

   // History memory: one write, one registered read; unfilled slots read zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[fill_ff[AB-1:0]] <= zr_new;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
         rd_ok_ff   <= (FB'(rd_addr) < fill_ff);
      end
   end

   // Assertions
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FB'(mop_pkg::HISTORY_DEPTH))
      else $error("history fill count beyond depth");

   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD) |->
      (best_ff != '0 && emit_idx_ff < best_ff))
      else $error("emit index outside found period");

   a_pending_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !out_last_ff) |->
      (state_ff == ST_EMIT_RD || state_ff == ST_EMIT_LD))
      else $error("non-final orbit item pending outside emit phase");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> (state_ff == ST_CMUL && !chk_ff))
      else $error("accepted item did not start the c computation");

endmodule

`default_nettype wire

// ===== tb/tb_mandelbrot_orbit_period_points.sv =====
// ---------------------------------------------------------------------------
// tb_mandelbrot_orbit_period_points - self-checking bench for the orbit block
// Sends grid points through the request channel under several register views,
// predicts the periodic orbit values of each non-escaping point and checks
// every result item in order, with random idling on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_mandelbrot_orbit_period_points;

   localparam int     STALL_LIMIT = 100000;
   localparam longint ONE_Q       = longint'(1) <<< mop_pkg::FRAC_BITS;
   localparam logic [mop_pkg::STEP_BITS-1:0] STEP_MAX = '1;
   localparam logic [mop_pkg::TOL_BITS-1:0]  TOL_MAX  = '1;

   typedef struct {
      mop_pkg::index_type col;
      mop_pkg::index_type row;
      mop_pkg::orbit_type orbit;
      logic               last;
   } orbit_rec_type;

   // Orbit predictor plus the queue of expected result items
   class orbit_scoreboard_type;
      longint        step      = longint'(mop_pkg::STEP_RESET);
      longint        max_iter  = longint'(mop_pkg::MAX_ITER_RESET);
      longint        tolerance = longint'(mop_pkg::TOL_RESET);
      orbit_rec_type orbit_q[$];
      int            mismatches = 0;

      function void set_reg(logic [mop_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [mop_pkg::CSR_DATA_BITS-1:0] val);
         case (idx)
            mop_pkg::CSR_COORD_STEP: step      = longint'(val[mop_pkg::STEP_BITS-1:0]);
            mop_pkg::CSR_MAX_ITER:   max_iter  = longint'(val[mop_pkg::COUNT_BITS-1:0]);
            mop_pkg::CSR_PERIOD_TOL: tolerance = longint'(val[mop_pkg::TOL_BITS-1:0]);
            default: ;
         endcase
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function int pending();
         return orbit_q.size();
      endfunction

      // Iterate the point and queue the orbit values up to the period found
      function void note_point(mop_pkg::index_type col, mop_pkg::index_type row);
         longint          cr, ci, zr, zi, rr, ii, ri, window, count, delta;
         longint          hist [mop_pkg::HISTORY_DEPTH];
         longint unsigned mag;
         int              stored, best, k;
         bit              in_disk, counted;
         orbit_rec_type   rec;
         cr = clamp32(longint'(col) * step - (longint'(2) <<< mop_pkg::FRAC_BITS));
         ci = clamp32(longint'(row) * step - (longint'(2) <<< mop_pkg::FRAC_BITS));
         window = max_iter - (mop_pkg::HISTORY_DEPTH - 1);
         for (k = 0; k < mop_pkg::HISTORY_DEPTH; k++) hist[k] = 0;
         zr = cr;
         zi = ci;
         count = 0;
         stored = 0;
         do begin
            rr = zr * zr;
            ii = zi * zi;
            ri = zr * zi;
            mag = longint'(rr) + longint'(ii);
            in_disk = mag < (64'd4 << (2 * mop_pkg::FRAC_BITS));
            zr = clamp32(((rr - ii) >>> mop_pkg::FRAC_BITS) + cr);
            zi = clamp32((ri >>> (mop_pkg::FRAC_BITS - 1)) + ci);
            counted = in_disk && (count < max_iter);
            if (counted) count++;
            // only the tail of the orbit is kept
            if (count > window) begin
               if (stored < mop_pkg::HISTORY_DEPTH) hist[stored] = zr;
               stored++;
            end
         end while (counted);
         if (count != max_iter) return;
         // largest lag that comes back within tolerance of the first value
         best = 0;
         for (k = 1; k < mop_pkg::HISTORY_DEPTH; k++) begin
            delta = hist[k] - hist[0];
            if (delta < 0) delta = -delta;
            if (delta < tolerance) best = k;
         end
         for (k = 0; k < best; k++) begin
            rec.col   = col;
            rec.row   = row;
            rec.orbit = mop_pkg::orbit_type'(hist[k]);
            rec.last  = (k == best - 1);
            orbit_q   = {orbit_q, rec};
         end
      endfunction

      function void check_orbit(mop_pkg::index_type col, mop_pkg::index_type row,
                                mop_pkg::orbit_type orbit, logic last);
         orbit_rec_type want;
         if (orbit_q.size() == 0) begin
            $error("orbit item with none expected: col %0d row %0d orbit %0d", col, row, orbit);
            mismatches++;
            return;
         end
         want = orbit_q.pop_front();
         if (col !== want.col) begin
            $error("out_col mismatch: expected %0d, actual %0d", want.col, col);
            mismatches++;
         end
         if (row !== want.row) begin
            $error("out_row mismatch: expected %0d, actual %0d", want.row, row);
            mismatches++;
         end
         if (orbit !== want.orbit) begin
            $error("orbit_real mismatch: expected %0d, actual %0d", want.orbit, orbit);
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last_value mismatch: expected %0d, actual %0d", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_wr_en = 1'b0;
   logic [mop_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [mop_pkg::CSR_DATA_BITS-1:0]  csr_wr_data = '0;
   bit                                 quiet_mode = 1'b0;
   orbit_scoreboard_type               sb = new();

   mop_req_if req_ch();
   mop_rsp_if rsp_ch();

   mandelbrot_orbit_period_points i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Send one grid point, with an optional idle burst ahead of it
   task automatic send_point(mop_pkg::index_type col, mop_pkg::index_type row);
      int gap;
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.col_index <= col;
      req_ch.row_index <= row;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_point(col, row);
   endtask

   // Wait out all expected items, then the longest point the block may still be on
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * sb.max_iter + 100) @(posedge clock);
   endtask

   task automatic write_reg(logic [mop_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [mop_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic load_view(logic [mop_pkg::STEP_BITS-1:0] step_v,
                            logic [mop_pkg::COUNT_BITS-1:0] iter_v,
                            logic [mop_pkg::TOL_BITS-1:0] tol_v);
      drain();
      write_reg(mop_pkg::CSR_COORD_STEP, step_v);
      write_reg(mop_pkg::CSR_MAX_ITER, mop_pkg::CSR_DATA_BITS'(iter_v));
      write_reg(mop_pkg::CSR_PERIOD_TOL, tol_v);
   endtask

   // Random index whose c lands within span of center on the current grid
   function automatic mop_pkg::index_type grid_index(longint center_q, longint span_q);
      longint lo, hi;
      lo = (center_q - span_q + 2 * ONE_Q + sb.step - 1) / sb.step;
      hi = (center_q + span_q + 2 * ONE_Q) / sb.step;
      if (lo < 0) lo = 0;
      if (lo > 4095) lo = 4095;
      if (hi > 4095) hi = 4095;
      if (hi < lo) hi = lo;
      return mop_pkg::index_type'($urandom_range(int'(hi), int'(lo)));
   endfunction

   // Result side: check accepted items, stall in bursts
   initial begin : orbit_sink
      int hold;
      hold = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_orbit(rsp_ch.out_col, rsp_ch.out_row, rsp_ch.orbit_real,
                           rsp_ch.last_value);
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
            hold = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: too long without any item moving on either channel
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int                                phase, n, region;
      logic [mop_pkg::STEP_BITS-1:0]     step_v;
      logic [mop_pkg::COUNT_BITS-1:0]    iter_v;
      logic [mop_pkg::TOL_BITS-1:0]      tol_v;
      longint                            re_c, re_s, im_c, im_s;

      req_ch.valid     = 1'b0;
      req_ch.col_index = '0;
      req_ch.row_index = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset view: immediate escape, field extremes, cardioid, period-2 bulb,
      // cusp boundary and points beyond it
      send_point(12'd0, 12'd0);
      send_point(12'd4095, 12'd4095);
      send_point(12'd0, 12'd4095);
      send_point(12'd4095, 12'd0);
      send_point(12'd500, 12'd500);
      send_point(12'd250, 12'd500);
      send_point(12'd375, 12'd500);
      send_point(12'd562, 12'd500);
      send_point(12'd600, 12'd500);
      send_point(12'd0, 12'd500);
      send_point(12'hAAA, 12'h555);
      send_point(12'h555, 12'hAAA);

      // Zero step pins c to -2-2i; zero limit makes every point non-escaping
      load_view('0, '0, TOL_MAX);
      send_point(12'd0, 12'd0);
      send_point(12'd4095, 12'd4095);
      load_view(mop_pkg::STEP_RESET, '0, mop_pkg::TOL_RESET << 17);
      send_point(12'd500, 12'd500);
      send_point(12'd250, 12'd500);

      // Limits around the history depth; zero tolerance matches nothing
      load_view(mop_pkg::STEP_RESET, 12'd19, 28'h100_0000);
      send_point(12'd375, 12'd500);
      load_view(mop_pkg::STEP_RESET, 12'd20, 28'h100_0000);
      send_point(12'd250, 12'd500);
      load_view(mop_pkg::STEP_RESET, 12'd21, '0);
      send_point(12'd500, 12'd500);

      // Widest step with the longest limit, saturated c included
      load_view(STEP_MAX, 12'd4095, mop_pkg::TOL_RESET);
      send_point(12'd1, 12'd2);
      send_point(12'd2, 12'd2);
      send_point(12'd4095, 12'd4095);

      // Random views: mostly points aimed at the set, some anywhere
      for (phase = 0; phase < 9; phase++) begin
         case ($urandom_range(0, 3))
            0:       step_v = mop_pkg::STEP_RESET;
            3:       step_v = mop_pkg::STEP_BITS'($urandom_range(1, int'(STEP_MAX)));
            default: step_v = mop_pkg::STEP_BITS'($urandom_range(1 << 17, 1 << 22));
         endcase
         case ($urandom_range(0, 9))
            0:       iter_v = mop_pkg::MAX_ITER_RESET;
            1:       iter_v = mop_pkg::COUNT_BITS'($urandom_range(0, 19));
            default: iter_v = mop_pkg::COUNT_BITS'($urandom_range(20, 300));
         endcase
         case ($urandom_range(0, 3))
            0:       tol_v = mop_pkg::TOL_RESET;
            1:       tol_v = '0;
            2:       tol_v = mop_pkg::TOL_BITS'(1) << $urandom_range(4, 27);
            default: tol_v = mop_pkg::TOL_BITS'($urandom_range(0, int'(TOL_MAX)));
         endcase
         load_view(step_v, iter_v, tol_v);
         quiet_mode = (phase == 8) || ($urandom_range(0, 4) == 0);
         for (n = 0; n < 25; n++) begin
            region = $urandom_range(0, 4);
            case (region)
               0: begin // main cardioid
                  re_c = -ONE_Q / 10;   re_s = ONE_Q * 35 / 100;
                  im_c = 0;             im_s = ONE_Q * 4 / 10;
               end
               1: begin // period-2 bulb
                  re_c = -ONE_Q;        re_s = ONE_Q / 5;
                  im_c = 0;             im_s = ONE_Q / 6;
               end
               2: begin // whole set and its surroundings
                  re_c = -ONE_Q * 3 / 4; re_s = ONE_Q * 13 / 10;
                  im_c = 0;              im_s = ONE_Q * 12 / 10;
               end
               default: begin
                  re_c = 0; re_s = 0; im_c = 0; im_s = 0;
               end
            endcase
            if (region > 2)
               send_point(mop_pkg::index_type'($urandom_range(0, 4095)),
                          mop_pkg::index_type'($urandom_range(0, 4095)));
            else
               send_point(grid_index(re_c, re_s), grid_index(im_c, im_s));
         end
      end

      drain();
      if (sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
